@@ hdl/vt52_pkg.sv @@
package vt52_pkg;

  typedef enum logic [4:0] {
    CMD_NONE    = 5'd0,
    CMD_ADDCH   = 5'd1,
    CMD_SETATTR = 5'd2,
    CMD_CLRATTR = 5'd3,
    CMD_UP      = 5'd4,
    CMD_DOWN    = 5'd5,
    CMD_RIGHT   = 5'd6,
    CMD_LEFT    = 5'd7,
    CMD_CLEAR   = 5'd8,
    CMD_MOVE    = 5'd9,
    CMD_EOS     = 5'd10,
    CMD_EOL     = 5'd11,
    CMD_INSLN   = 5'd12,
    CMD_DELLN   = 5'd13,
    CMD_DELCH   = 5'd14,
    CMD_WINDOW  = 5'd15,
    CMD_FG      = 5'd16,
    CMD_BG      = 5'd17,
    CMD_BOS     = 5'd18,
    CMD_CURSOR  = 5'd19,
    CMD_SAVEPOS = 5'd20,
    CMD_CLRLINE = 5'd21,
    CMD_BOL     = 5'd22,
    CMD_WRAP    = 5'd23,
    CMD_24X80   = 5'd24,
    CMD_FULLSCR = 5'd25,
    CMD_TAB     = 5'd26,
    CMD_CR      = 5'd27
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [8:0]  a;
    logic signed [8:0]  b;
    logic signed [8:0]  c;
    logic signed [8:0]  d;
    logic               refresh;
    logic               last;
  } res_t;

  // Most commands a single byte can produce.
  localparam int MAX_RES = 2;

endpackage

@@ hdl/vt52_decode.sv @@
module vt52_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_q,
  output vt52_pkg::res_t      res0,
  output vt52_pkg::res_t      res1,
  output logic [1:0]          res_n
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_X    = 3'd2,
    PH_Y    = 3'd3,
    PH_B    = 3'd4,
    PH_C    = 3'd5
  } phase_t;

  localparam logic [7:0] CH_HOME1 = 8'd1;
  localparam logic [7:0] CH_ATOFF = 8'd2;
  localparam logic [7:0] CH_CLR1  = 8'd4;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_HT    = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_CAN   = 8'd24;
  localparam logic [7:0] CH_CLR2  = 8'd26;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_HOME2 = 8'd30;
  localparam logic [7:0] CH_NL    = 8'd31;

  phase_t      phase, phase_next;
  logic [2:0]  pending, pending_next;
  logic        wrap, wrap_next;
  logic [7:0]  abuf [4];
  logic [7:0]  buf_w [4];
  logic        abuf_we;
  logic [2:0]  total;
  logic [2:0]  pend_eff;
  logic [2:0]  pend_dec;
  logic [1:0]  idx;

  function automatic vt52_pkg::res_t mk(input vt52_pkg::cmd_t c,
                                        input logic signed [8:0] a,
                                        input logic rf);
    vt52_pkg::res_t r;
    r         = '0;
    r.cmd     = c;
    r.a       = a;
    r.refresh = rf;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic logic signed [8:0] off(input logic [7:0] v, input logic [8:0] k);
    return $signed({1'b0, v} - k);
  endfunction

  // Fold (v - 32) mod 64 into a 3-bit colour index, one bit per 2-bit group.
  function automatic logic signed [8:0] fold(input logic [7:0] v);
    logic [7:0] n;
    n = v - 8'd32;
    return $signed({6'd0, |n[5:4], |n[3:2], |n[1:0]});
  endfunction

  always_comb begin
    case (phase)
      PH_X:    total = 3'd4;
      PH_Y:    total = 3'd2;
      default: total = 3'd1;
    endcase
    pend_eff = (pending == 3'd0 || pending > total) ? total : pending;
    pend_dec = pend_eff - 3'd1;
    idx      = 2'(total - pend_eff);
    for (int i = 0; i < 4; i++) begin
      buf_w[i] = (idx == 2'(i)) ? byte_q : abuf[i];
    end
  end

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    wrap_next    = wrap;
    abuf_we      = 1'b0;
    res0         = mk(vt52_pkg::CMD_NONE, 9'sd0, 1'b0);
    res1         = '0;
    res_n        = 2'd1;
    case (phase)
      PH_ESC: begin
        phase_next = PH_IDLE;
        case (byte_q)
          "(":  res0 = mk(vt52_pkg::CMD_SETATTR, 9'sd0, 1'b0);
          ")":  res0 = mk(vt52_pkg::CMD_CLRATTR, 9'sd0, 1'b0);
          "A":  res0 = mk(vt52_pkg::CMD_UP, 9'sd0, 1'b1);
          "B":  res0 = mk(vt52_pkg::CMD_DOWN, 9'sd0, 1'b1);
          "C":  res0 = mk(vt52_pkg::CMD_RIGHT, 9'sd0, 1'b1);
          "D":  res0 = mk(vt52_pkg::CMD_LEFT, 9'sd0, 1'b1);
          "*", "+", ",", ":", ";", "E":
                res0 = mk(vt52_pkg::CMD_CLEAR, 9'sd0, 1'b1);
          "H":  res0 = mk(vt52_pkg::CMD_MOVE, 9'sd0, 1'b1);
          "I":  res0 = mk(vt52_pkg::CMD_UP, 9'sd1, 1'b1);
          "J":  res0 = mk(vt52_pkg::CMD_EOS, 9'sd0, 1'b1);
          "K":  res0 = mk(vt52_pkg::CMD_EOL, 9'sd0, 1'b1);
          "L":  res0 = mk(vt52_pkg::CMD_INSLN, 9'sd0, 1'b1);
          "M", "R":
                res0 = mk(vt52_pkg::CMD_DELLN, 9'sd0, 1'b1);
          "N":  res0 = mk(vt52_pkg::CMD_DELCH, 9'sd0, 1'b1);
          "X": begin
            phase_next   = PH_X;
            pending_next = 3'd4;
          end
          "Y": begin
            phase_next   = PH_Y;
            pending_next = 3'd2;
          end
          "b": begin
            phase_next   = PH_B;
            pending_next = 3'd1;
          end
          "c": begin
            phase_next   = PH_C;
            pending_next = 3'd1;
          end
          "d":  res0 = mk(vt52_pkg::CMD_BOS, 9'sd0, 1'b1);
          "e":  res0 = mk(vt52_pkg::CMD_CURSOR, 9'sd1, 1'b0);
          "f":  res0 = mk(vt52_pkg::CMD_CURSOR, 9'sd0, 1'b0);
          "j":  res0 = mk(vt52_pkg::CMD_SAVEPOS, 9'sd0, 1'b0);
          "k":  res0 = mk(vt52_pkg::CMD_SAVEPOS, 9'sd1, 1'b1);
          "l":  res0 = mk(vt52_pkg::CMD_CLRLINE, 9'sd0, 1'b1);
          "o":  res0 = mk(vt52_pkg::CMD_BOL, 9'sd0, 1'b1);
          "p":  res0 = mk(vt52_pkg::CMD_SETATTR, 9'sd1, 1'b0);
          "q":  res0 = mk(vt52_pkg::CMD_CLRATTR, 9'sd1, 1'b0);
          "r":  res0 = mk(vt52_pkg::CMD_SETATTR, 9'sd2, 1'b0);
          "s":  res0 = mk(vt52_pkg::CMD_SETATTR, 9'sd3, 1'b0);
          "t":  res0 = mk(vt52_pkg::CMD_CLRATTR, 9'sd3, 1'b0);
          "u":  res0 = mk(vt52_pkg::CMD_CLRATTR, 9'sd2, 1'b0);
          "w": begin
            wrap_next = 1'b1;
            res0      = mk(vt52_pkg::CMD_WRAP, 9'sd1, 1'b0);
          end
          "v": begin
            wrap_next = 1'b0;
            res0      = mk(vt52_pkg::CMD_WRAP, 9'sd0, 1'b0);
          end
          "x":  res0 = mk(vt52_pkg::CMD_24X80, 9'sd0, 1'b1);
          "y":  res0 = mk(vt52_pkg::CMD_FULLSCR, 9'sd0, 1'b1);
          // unknown letter prints as a character
          default: res0 = mk(vt52_pkg::CMD_ADDCH, $signed({1'b0, byte_q}), 1'b1);
        endcase
      end
      PH_X, PH_Y, PH_B, PH_C: begin
        abuf_we      = 1'b1;
        pending_next = pend_dec;
        if (pend_dec == 3'd0) begin
          phase_next = PH_IDLE;
          case (phase)
            PH_B: res0 = mk(vt52_pkg::CMD_FG, fold(buf_w[0]), 1'b1);
            PH_C: res0 = mk(vt52_pkg::CMD_BG, fold(buf_w[0]), 1'b1);
            PH_X: begin
              res0   = mk(vt52_pkg::CMD_WINDOW, off(buf_w[0], 9'd32), 1'b1);
              res0.b = off(buf_w[1], 9'd32);
              res0.c = off(buf_w[2], 9'd31);
              res0.d = off(buf_w[3], 9'd31);
            end
            default: begin
              res0   = mk(vt52_pkg::CMD_MOVE, off(buf_w[1], 9'd32), 1'b1);
              res0.b = off(buf_w[0], 9'd32);
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_IDLE;
        case (byte_q)
          CH_HOME1, CH_HOME2: res0 = mk(vt52_pkg::CMD_MOVE, 9'sd0, 1'b1);
          CH_ATOFF: res0 = mk(vt52_pkg::CMD_CLRATTR, 9'sd0, 1'b0);
          CH_CLR1, CH_CLR2: begin
            res0      = mk(vt52_pkg::CMD_CLEAR, 9'sd0, 1'b1);
            res0.last = 1'b0;
            res1      = mk(vt52_pkg::CMD_MOVE, 9'sd0, 1'b1);
            res_n     = 2'd2;
          end
          CH_BS:  res0 = mk(vt52_pkg::CMD_LEFT, $signed({8'd0, wrap}), 1'b1);
          CH_HT:  res0 = mk(vt52_pkg::CMD_TAB, 9'sd0, 1'b1);
          CH_LF:  res0 = mk(vt52_pkg::CMD_DOWN, 9'sd1, 1'b1);
          CH_VT:  res0 = mk(vt52_pkg::CMD_UP, 9'sd0, 1'b1);
          CH_FF:  res0 = mk(vt52_pkg::CMD_CLEAR, 9'sd0, 1'b1);
          CH_CR:  res0 = mk(vt52_pkg::CMD_CR, 9'sd0, 1'b1);
          CH_CAN: res0 = mk(vt52_pkg::CMD_EOL, 9'sd0, 1'b1);
          CH_ESC: phase_next = PH_ESC;
          CH_NL: begin
            res0      = mk(vt52_pkg::CMD_CR, 9'sd0, 1'b1);
            res0.last = 1'b0;
            res1      = mk(vt52_pkg::CMD_DOWN, 9'sd1, 1'b1);
            res_n     = 2'd2;
          end
          default: res0 = mk(vt52_pkg::CMD_ADDCH, $signed({1'b0, byte_q}), 1'b1);
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= 3'd0;
      wrap    <= 1'b0;
    end else if (fire) begin
      phase   <= phase_next;
      pending <= pending_next;
      wrap    <= wrap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && abuf_we) begin
      abuf[idx] <= byte_q;
    end
  end

  a_two_last: assert property (@(posedge clk) disable iff (rst)
    (fire && res_n == 2'd2) |-> (!res0.last && res1.last))
    else $error("two-command byte marks the wrong result as last");

  a_one_last: assert property (@(posedge clk) disable iff (rst)
    (fire && res_n == 2'd1) |-> res0.last)
    else $error("single result not marked last");

  a_x_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_X) |-> (pending != 3'd0 && pending <= 3'd4))
    else $error("window argument count out of range");

endmodule

@@ hdl/vt52_queue.sv @@
module vt52_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  vt52_pkg::res_t      d0,
  input  vt52_pkg::res_t      d1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output vt52_pkg::res_t      head
);

  localparam int DEPTH = 2 * vt52_pkg::MAX_RES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  vt52_pkg::res_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Take a new byte only when its worst case fits.
  assign room      = (count <= CW'(DEPTH - vt52_pkg::MAX_RES));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_n);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push_n) - CW'(pop);
    end
  end

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ((CW + 1)'(count) + (CW + 1)'(push_n) <= (CW + 1)'(DEPTH)))
    else $error("result queue overflow");

endmodule

@@ hdl/vt52_escape_decoder.sv @@
// VT52 escape decoder: one terminal byte in per word, numbered display commands
// out. A byte is registered, decoded against the escape state once the result queue
// has room, and the result is written to that queue, whose head drives the output.
// One byte is taken every cycle while the output keeps pace; Ctrl-D, Ctrl-Z and
// code 31 produce two command words, so those bytes fill two queue entries, and
// the four-entry result queue sets how long input keeps flowing when the output
// stalls. Bytes that only advance an escape sequence give a command-0 word.
module vt52_escape_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         command,
  output logic signed [8:0]  arg_a,
  output logic signed [8:0]  arg_b,
  output logic signed [8:0]  arg_c,
  output logic signed [8:0]  arg_d,
  output logic               refresh,
  output logic               last
);

  logic            full;
  logic [7:0]      byte_q;
  logic            room;
  logic            move;
  logic            accept;
  logic [1:0]      res_n;
  logic [1:0]      push_n;
  vt52_pkg::res_t  res0;
  vt52_pkg::res_t  res1;
  vt52_pkg::res_t  head;

  assign move     = full && room;
  assign in_stall = full && !room;
  assign accept   = in_valid && !in_stall;
  assign push_n   = move ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (move) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= byte_in;
    end
  end

  vt52_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .byte_q (byte_q),
    .res0   (res0),
    .res1   (res1),
    .res_n  (res_n)
  );

  vt52_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign command = head.cmd;
  assign arg_a   = head.a;
  assign arg_b   = head.b;
  assign arg_c   = head.c;
  assign arg_d   = head.d;
  assign refresh = head.refresh;
  assign last    = head.last;

endmodule
